// ===== design/tafa_pkg.sv =====
// ----------------------------------------------------------------------------
// tafa_pkg
// Shared types and constants of the attractive force accumulator: the
// queue entry passed from the front end to the back end and field widths.
// ----------------------------------------------------------------------------
package tafa_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int AFF_W   = 32;
  localparam int MAG_W   = 32;
  localparam int FORCE_W = 64;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int PROD_W  = AFF_W + MAG_W;
  localparam int FRAC_DROP = 16;

  // packed stream widths
  localparam int IN_DATA_W  = 4 * COORD_W + AFF_W;
  localparam int OUT_DATA_W = 2 * FORCE_W;

  // queue between front end and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified edge word
  typedef struct packed {
    logic [AFF_W-1:0] affinity;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic             neg_x;
    logic             neg_y;
    logic             edge_valid;
    logic             row_last;
  } entry_t;

  // queue handshake between stages
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== design/tsne_attractive_force_accumulator.sv =====
// Per edge word the back end runs pop, two squares, denominator, 32 divider
// steps at one quotient bit per cycle (skipped, q zero, if the denominator
// overflows), two products and accumulate, popping no new word until done.
// A row close loads the output word in an emit state once the output is free;
// valid shows in the cycle after. The input side fills a 4-word queue while it
// has room. Reset (rst, synchronous) empties queue and output, zeroes force.
// ----------------------------------------------------------------------------
// tsne_attractive_force_accumulator
// Accumulates the t-SNE attractive force of each row of a sparse affinity
// matrix in saturating signed Q31.32 and emits it when the row closes.
// ----------------------------------------------------------------------------
module tsne_attractive_force_accumulator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // row_x, row_y, nbr_x, nbr_y, affinity
  input  logic [tafa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // edge_valid
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // force_x, force_y
  output logic [tafa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // saturated
  output logic                            m_axis_tuser
);
  import tafa_pkg::*;

  q_ctrl_t            q_ctrl;
  q_stat_t            q_stat;
  entry_t             push_data;
  entry_t             pop_data;
  logic               push;
  logic               pop;
  logic [FORCE_W-1:0] force_x;
  logic [FORCE_W-1:0] force_y;

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  // front end: classify and form distances
  tafa_front u_front (
    .row_x      (s_axis_tdata[COORD_W-1:0]),
    .row_y      (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .nbr_x      (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
    .nbr_y      (s_axis_tdata[4*COORD_W-1:3*COORD_W]),
    .affinity   (s_axis_tdata[4*COORD_W+AFF_W-1:4*COORD_W]),
    .edge_valid (s_axis_tuser),
    .row_last   (s_axis_tlast),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  // decoupling queue
  tafa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .q_ctrl    (q_ctrl),
    .push_data (push_data),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // back end: divide, scale, accumulate
  tafa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_force_x (force_x),
    .out_force_y (force_y),
    .out_sat     (m_axis_tuser)
  );

  assign m_axis_tdata = {force_y, force_x};

endmodule

// ===== design/tafa_front.sv =====
// ----------------------------------------------------------------------------
// tafa_front
// Input side: accepts edge words, forms the per-axis distance magnitude and
// sign, and drops words that neither carry an edge nor close a row.
// ----------------------------------------------------------------------------
module tafa_front (
  input  logic [tafa_pkg::COORD_W-1:0] row_x,
  input  logic [tafa_pkg::COORD_W-1:0] row_y,
  input  logic [tafa_pkg::COORD_W-1:0] nbr_x,
  input  logic [tafa_pkg::COORD_W-1:0] nbr_y,
  input  logic [tafa_pkg::AFF_W-1:0]   affinity,
  input  logic                         edge_valid,
  input  logic                         row_last,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tafa_pkg::q_stat_t            q_stat,
  output logic                         push,
  output tafa_pkg::entry_t             push_data
);
  import tafa_pkg::*;

  logic [COORD_W:0] diff_x;
  logic [COORD_W:0] diff_y;
  logic [MAG_W-1:0] abs_x;
  logic [MAG_W-1:0] abs_y;

  // exact signed difference, one extra bit
  assign diff_x = {row_x[COORD_W-1], row_x} - {nbr_x[COORD_W-1], nbr_x};
  assign diff_y = {row_y[COORD_W-1], row_y} - {nbr_y[COORD_W-1], nbr_y};
  assign abs_x  = diff_x[COORD_W] ? MAG_W'(~diff_x + 1'b1) : diff_x[MAG_W-1:0];
  assign abs_y  = diff_y[COORD_W] ? MAG_W'(~diff_y + 1'b1) : diff_y[MAG_W-1:0];

  // accept whenever the queue has room
  assign in_ready = !q_stat.full;

  // only edges and row closes go to the back end
  assign push = in_valid && in_ready && (edge_valid || row_last);

  always_comb begin
    push_data.affinity   = affinity;
    push_data.mag_x      = abs_x;
    push_data.mag_y      = abs_y;
    push_data.neg_x      = diff_x[COORD_W];
    push_data.neg_y      = diff_y[COORD_W];
    push_data.edge_valid = edge_valid;
    push_data.row_last   = row_last;
  end

endmodule

// ===== design/tafa_queue.sv =====
// ----------------------------------------------------------------------------
// tafa_queue
// Short first-in first-out queue of classified words between the front end
// and the back end.
// ----------------------------------------------------------------------------
module tafa_queue (
  input  logic              clk,
  input  logic              rst,
  input  tafa_pkg::q_ctrl_t q_ctrl,
  input  tafa_pkg::entry_t  push_data,
  output tafa_pkg::entry_t  pop_data,
  output tafa_pkg::q_stat_t q_stat
);
  import tafa_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = q_ctrl.push && !q_stat.full;
  assign do_pop       = q_ctrl.pop && !q_stat.empty;
  assign pop_data     = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/tafa_back.sv =====
// ----------------------------------------------------------------------------
// tafa_back
// Execution side: forms q = p / (1 + d^2) with a bit-serial divider, scales
// the distance by q through one shared multiplier, accumulates with
// saturation and hands closed rows to the output register.
// ----------------------------------------------------------------------------
module tafa_back (
  input  logic                         clk,
  input  logic                         rst,
  input  tafa_pkg::q_stat_t            q_stat,
  input  tafa_pkg::entry_t             pop_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tafa_pkg::FORCE_W-1:0] out_force_x,
  output logic [tafa_pkg::FORCE_W-1:0] out_force_y,
  output logic                         out_sat
);
  import tafa_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_SQX  = 4'd1;
  localparam logic [ST_W-1:0] ST_SQY  = 4'd2;
  localparam logic [ST_W-1:0] ST_DEN  = 4'd3;
  localparam logic [ST_W-1:0] ST_DIV  = 4'd4;
  localparam logic [ST_W-1:0] ST_MULX = 4'd5;
  localparam logic [ST_W-1:0] ST_MULY = 4'd6;
  localparam logic [ST_W-1:0] ST_ACC  = 4'd7;
  localparam logic [ST_W-1:0] ST_EMIT = 4'd8;

  localparam int DEN_W  = SQ_W + 2;
  localparam int CNT_W  = $clog2(AFF_W);
  localparam int TERM_W = PROD_W - FRAC_DROP;

  logic [ST_W-1:0]    state;
  entry_t             cur;
  logic [SQ_W-1:0]    sq_x;
  logic [SQ_W-1:0]    sq_y;
  logic [SQ_W-1:0]    den;
  logic [SQ_W-1:0]    rem;
  logic [AFF_W-1:0]   quo;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  prod_x;
  logic [PROD_W-1:0]  prod_y;
  logic [FORCE_W-1:0] acc_x;
  logic [FORCE_W-1:0] acc_y;
  logic               sat_flag;

  logic [MAG_W-1:0]   mul_a;
  logic [MAG_W-1:0]   mul_b;
  logic [SQ_W-1:0]    mul_p;
  logic [DEN_W-1:0]   den_sum;
  logic               den_big;
  logic [SQ_W:0]      rem_sh;
  logic               rem_ge;
  logic [SQ_W:0]      rem_sub;
  logic [FORCE_W-1:0] term_x;
  logic [FORCE_W-1:0] term_y;
  logic [FORCE_W:0]   sum_x;
  logic [FORCE_W:0]   sum_y;
  logic               ovf_x;
  logic               ovf_y;
  logic [FORCE_W-1:0] acc_x_next;
  logic [FORCE_W-1:0] acc_y_next;
  logic               out_free;

  assign pop      = (state == ST_IDLE) && !q_stat.empty;
  assign out_free = !out_valid || out_ready;

  // shared 32x32 multiplier operand select
  always_comb begin
    case (state)
      ST_SQX: begin
        mul_a = cur.mag_x;
        mul_b = cur.mag_x;
      end
      ST_SQY: begin
        mul_a = cur.mag_y;
        mul_b = cur.mag_y;
      end
      ST_MULX: begin
        mul_a = quo;
        mul_b = cur.mag_x;
      end
      default: begin
        mul_a = quo;
        mul_b = cur.mag_y;
      end
    endcase
  end
  assign mul_p = SQ_W'(mul_a) * SQ_W'(mul_b);

  // denominator 1 + dx^2 + dy^2 in Q32.32
  assign den_sum = {2'b00, sq_x} + {2'b00, sq_y} + (DEN_W'(1) << AFF_W);
  assign den_big = |den_sum[DEN_W-1:SQ_W];

  // one restoring division step
  assign rem_sh  = {rem, 1'b0};
  assign rem_ge  = (rem_sh >= {1'b0, den});
  assign rem_sub = rem_sh - {1'b0, den};

  // signed terms, truncated toward zero
  assign term_x = cur.neg_x ? (~FORCE_W'(prod_x[PROD_W-1:FRAC_DROP]) + 1'b1)
                            : FORCE_W'(prod_x[PROD_W-1:FRAC_DROP]);
  assign term_y = cur.neg_y ? (~FORCE_W'(prod_y[PROD_W-1:FRAC_DROP]) + 1'b1)
                            : FORCE_W'(prod_y[PROD_W-1:FRAC_DROP]);

  // saturating accumulate
  assign sum_x = {acc_x[FORCE_W-1], acc_x} + {term_x[FORCE_W-1], term_x};
  assign sum_y = {acc_y[FORCE_W-1], acc_y} + {term_y[FORCE_W-1], term_y};
  assign ovf_x = sum_x[FORCE_W] != sum_x[FORCE_W-1];
  assign ovf_y = sum_y[FORCE_W] != sum_y[FORCE_W-1];

  always_comb begin
    if (ovf_x) begin
      acc_x_next = sum_x[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}}
                                  : {1'b0, {(FORCE_W-1){1'b1}}};
    end else begin
      acc_x_next = sum_x[FORCE_W-1:0];
    end
    if (ovf_y) begin
      acc_y_next = sum_y[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}}
                                  : {1'b0, {(FORCE_W-1){1'b1}}};
    end else begin
      acc_y_next = sum_y[FORCE_W-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop) begin
          cur <= pop_data;
        end
      end
      ST_SQX: sq_x <= mul_p;
      ST_SQY: sq_y <= mul_p;
      ST_DEN: begin
        den <= den_sum[SQ_W-1:0];
        rem <= SQ_W'(cur.affinity);
        quo <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        rem <= rem_ge ? rem_sub[SQ_W-1:0] : rem_sh[SQ_W-1:0];
        quo <= {quo[AFF_W-2:0], rem_ge};
        cnt <= cnt + 1'b1;
      end
      ST_MULX: prod_x <= mul_p;
      ST_MULY: prod_y <= mul_p;
      default: begin
      end
    endcase
  end

  // sequencer, accumulators and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      acc_x     <= '0;
      acc_y     <= '0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output word valid: set on a row close, cleared when taken
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= pop_data.edge_valid ? ST_SQX : ST_EMIT;
          end
        end
        ST_SQX: state <= ST_SQY;
        ST_SQY: state <= ST_DEN;
        ST_DEN: state <= den_big ? ST_MULX : ST_DIV;
        ST_DIV: begin
          if (cnt == CNT_W'(AFF_W - 1)) begin
            state <= ST_MULX;
          end
        end
        ST_MULX: state <= ST_MULY;
        ST_MULY: state <= ST_ACC;
        ST_ACC: begin
          acc_x    <= acc_x_next;
          acc_y    <= acc_y_next;
          sat_flag <= sat_flag | ovf_x | ovf_y;
          state    <= cur.row_last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_force_x <= acc_x;
            out_force_y <= acc_y;
            out_sat     <= sat_flag;
            acc_x       <= '0;
            acc_y       <= '0;
            sat_flag    <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
